/* rtl/core/mlfq_scheduler_with_aging_defines.svh */
// assertion macros for the scheduler
`ifndef MLFQ_SCHEDULER_WITH_AGING_DEFINES_SVH
`define MLFQ_SCHEDULER_WITH_AGING_DEFINES_SVH
`define MLFQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MLFQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/core/mlfq_pkg.sv */
// ----------------------------------------------------------------------------
// mlfq_pkg
// types and constants shared by the scheduler core
// ----------------------------------------------------------------------------
`default_nettype none
package mlfq_pkg;
  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int LEVELS = 3;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_REQUEUED = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_IDLE = 3'd4;

  localparam logic [1:0] REG_Q0 = 2'd0;
  localparam logic [1:0] REG_Q1 = 2'd1;
  localparam logic [1:0] REG_Q2 = 2'd2;
  localparam logic [1:0] REG_AGE = 2'd3;

  localparam logic [15:0] Q0_RESET = 16'd2;
  localparam logic [15:0] Q1_RESET = 16'd4;
  localparam logic [15:0] Q2_RESET = 16'd1000;
  localparam logic [15:0] AGE_RESET = 16'd8;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] burst_len;
    logic [7:0]  task_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  task_slot;
    logic [7:0]  tag_out;
    logic [1:0]  level_run;
    logic [15:0] run_time;
    logic [15:0] remaining_after;
    logic [4:0]  promoted_count;
    logic [31:0] elapsed_time;
  } out_item_t;

  // task record passed along the chain
  typedef struct packed {
    logic              used;
    logic [15:0]       remaining;
    logic [1:0]        level;
    logic [15:0]       waiting;
    logic [7:0]        label;
    logic [CNT_W-1:0]  seq;
  } task_t;

  // queue rank closed up behind a promoted task
  typedef struct packed {
    logic              vld;
    logic [1:0]        level;
    logic [CNT_W-1:0]  seq;
  } close_t;
endpackage
`default_nettype wire

/* rtl/core/mlfq_cell.sv */
// ----------------------------------------------------------------------------
// mlfq_cell
// one task slot of the rotating slot chain, closes queue ranks on the way
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_cell import mlfq_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire logic   load_i,
  input  wire task_t  load_rec_i,
  input  wire task_t  rec_i,
  input  wire close_t close_i,
  output task_t       rec_o
);
  task_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_i;
    if (close_i.vld && rec_i.used && rec_i.level == close_i.level &&
        rec_i.seq > close_i.seq) begin
      rec_d.seq = rec_i.seq - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (load_i) begin
      rec_q <= load_rec_i;
    end else if (shift_i) begin
      rec_q <= rec_d;
    end
  end
  assign rec_o = rec_q;
endmodule
`default_nettype wire

/* rtl/core/mlfq_scheduler_with_aging.sv */
// ----------------------------------------------------------------------------
// mlfq_scheduler_with_aging
// three-level feedback-queue scheduler with aging over a ring of slot cells
// ----------------------------------------------------------------------------
// The slot records sit in a ring of cells that rotates once per pass; the
// record at the tap is examined and updated: one pass finds the free slot or
// the queue head, a second pass (dispatch only) ages and promotes in slot
// order, and the fix state then files the dispatched task. A dispatch with
// nothing ready skips the passes and goes straight to its result. Queue order
// is kept as a per-level rank in each record. One item is worked at a time;
// its result waits in an output register, and a result not yet taken holds
// the next item in its done state. Configuration writes go ahead of a new
// item when both are offered.
`default_nettype none
module mlfq_scheduler_with_aging import mlfq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
`include "mlfq_scheduler_with_aging_defines.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_FIND = 5'b00010, S_AGE = 5'b00100,
    S_FIX = 5'b01000, S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [15:0] q0_q, q0_d, q1_q, q1_d, q2_q, q2_d, age_q, age_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [CNT_W-1:0] cnt_q [LEVELS];
  logic [CNT_W-1:0] cnt_d [LEVELS];
  logic [SLOT_W-1:0] pos_q, pos_d;
  in_item_t item_q, item_d;
  logic found_q, found_d;
  logic [SLOT_W-1:0] sel_q, sel_d;
  logic [1:0] lvl_q, lvl_d;
  logic [15:0] run_q, run_d;
  task_t sel_rec_q, sel_rec_d;
  logic [4:0] prom_q, prom_d;
  out_item_t res_q, res_d;
  logic res_v_q, res_v_d;

  task_t chain [TASK_SLOTS];
  task_t tap, tap_new, load_rec;
  close_t close_bc;
  logic shift, load_en;

  // cells, chain index 0 is the tap; rotation by one each shift
  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    task_t next_rec;
    if (g == TASK_SLOTS - 1) begin : g_last
      assign next_rec = tap_new;
    end else begin : g_mid
      assign next_rec = chain[g + 1];
    end
    mlfq_cell u_cell (
      .clk_i(clk_i), .rst_ni(rst_ni), .shift_i(shift),
      .load_i(load_en && (sel_q == SLOT_W'(g))), .load_rec_i(load_rec),
      .rec_i(next_rec), .close_i(close_bc),
      .rec_o(chain[g]));
  end
  assign tap = chain[0];

  logic last, none_ready;
  logic [1:0] lvl_pick, lvl_next;
  assign last = pos_q == SLOT_W'(TASK_SLOTS - 1);
  assign none_ready = (cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0);
  assign lvl_pick = (cnt_q[0] != '0) ? 2'd0 : ((cnt_q[1] != '0) ? 2'd1 : 2'd2);
  assign lvl_next = (lvl_q == 2'd2) ? 2'd2 : lvl_q + 2'd1;

  logic [16:0] wsum;
  logic [15:0] wsat;
  always_comb begin
    wsum = {1'b0, tap.waiting} + {1'b0, run_q};
    wsat = wsum[16] ? 16'hFFFF : wsum[15:0];
  end
  logic [15:0] quant, run_new;
  always_comb begin
    unique case (lvl_q)
      2'd0: quant = q0_q;
      2'd1: quant = q1_q;
      default: quant = q2_q;
    endcase
  end
  assign run_new = (tap.remaining < quant) ? tap.remaining : quant;

  always_comb begin
    state_d = state_q;
    q0_d = q0_q; q1_d = q1_q; q2_d = q2_q; age_d = age_q;
    elapsed_d = elapsed_q;
    cnt_d = cnt_q;
    pos_d = pos_q; item_d = item_q; found_d = found_q; sel_d = sel_q;
    lvl_d = lvl_q; run_d = run_q; sel_rec_d = sel_rec_q; prom_d = prom_q;
    res_d = res_q; res_v_d = res_v_q;
    tap_new = tap;
    close_bc = '0;
    load_rec = sel_rec_q;
    load_en = 1'b0;
    shift = 1'b0;
    if (out_valid_o && out_ready_i) res_v_d = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_Q0: q0_d = cfg_data_i;
        REG_Q1: q1_d = cfg_data_i;
        REG_Q2: q2_d = cfg_data_i;
        REG_AGE: age_d = cfg_data_i;
      endcase
    end
    unique case (state_q)
      S_IDLE: begin
        pos_d = '0; found_d = 1'b0; prom_d = '0;
        if (in_valid_i && in_ready_o) begin
          item_d = in_data_i;
          lvl_d = lvl_pick;
          state_d = (in_data_i.op == OP_RUN && none_ready) ? S_DONE : S_FIND;
        end
      end
      S_FIND: begin
        shift = 1'b1;
        pos_d = pos_q + SLOT_W'(1);
        if (item_q.op == OP_ADD) begin
          if (!tap.used && !found_q) begin
            found_d = 1'b1; sel_d = pos_q;
            tap_new = '{used: 1'b1, remaining: item_q.burst_len, level: 2'd0,
                        waiting: 16'd0, label: item_q.task_tag, seq: cnt_q[0]};
          end
        end else if (tap.used && tap.level == lvl_q) begin
          tap_new.seq = tap.seq - CNT_W'(1);
          if (tap.seq == '0) begin
            found_d = 1'b1; sel_d = pos_q; run_d = run_new;
            sel_rec_d = tap;
            sel_rec_d.remaining = tap.remaining - run_new;
          end
        end
        if (last) begin
          pos_d = '0;
          if (item_q.op == OP_ADD) begin
            if (found_d) cnt_d[0] = cnt_q[0] + CNT_W'(1);
            state_d = S_DONE;
          end else begin
            for (int l = 0; l < LEVELS; l++) begin
              if (lvl_q == 2'(l)) cnt_d[l] = cnt_q[l] - CNT_W'(1);
            end
            state_d = S_AGE;
          end
        end
      end
      S_AGE: begin
        shift = 1'b1;
        pos_d = pos_q + SLOT_W'(1);
        if (tap.used && pos_q != sel_q) begin
          tap_new.waiting = wsat;
          if (tap.level != 2'd0 && wsat >= age_q) begin
            tap_new.level = 2'd0;
            tap_new.waiting = 16'd0;
            tap_new.seq = cnt_q[0];
            close_bc = '{vld: 1'b1, level: tap.level, seq: tap.seq};
            cnt_d[0] = cnt_q[0] + CNT_W'(1);
            for (int l = 1; l < LEVELS; l++) begin
              if (tap.level == 2'(l)) cnt_d[l] = cnt_q[l] - CNT_W'(1);
            end
            prom_d = prom_q + 5'd1;
          end
        end
        if (last) begin
          pos_d = '0;
          elapsed_d = elapsed_q + {16'd0, run_q};
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        load_en = 1'b1;
        if (sel_rec_q.remaining == 16'd0) begin
          load_rec.used = 1'b0;
        end else begin
          load_rec.level = lvl_next;
          for (int l = 0; l < LEVELS; l++) begin
            if (lvl_next == 2'(l)) begin
              load_rec.seq = cnt_q[l];
              cnt_d[l] = cnt_q[l] + CNT_W'(1);
            end
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!res_v_q || out_ready_i) begin
          res_v_d = 1'b1;
          state_d = S_IDLE;
          res_d = '0;
          res_d.elapsed_time = elapsed_q;
          if (item_q.op == OP_ADD) begin
            if (found_q) begin
              res_d.status = ST_ADDED;
              res_d.task_slot = 4'(sel_q);
              res_d.tag_out = item_q.task_tag;
              res_d.remaining_after = item_q.burst_len;
            end else begin
              res_d.status = ST_FULL;
            end
          end else if (found_q) begin
            res_d.status = (sel_rec_q.remaining == 16'd0) ? ST_FINISHED : ST_REQUEUED;
            res_d.task_slot = 4'(sel_q);
            res_d.tag_out = sel_rec_q.label;
            res_d.level_run = lvl_q;
            res_d.run_time = run_q;
            res_d.remaining_after = sel_rec_q.remaining;
            res_d.promoted_count = prom_q;
          end else begin
            res_d.status = ST_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      q0_q <= Q0_RESET; q1_q <= Q1_RESET; q2_q <= Q2_RESET; age_q <= AGE_RESET;
      elapsed_q <= '0;
      cnt_q <= '{default: '0};
      pos_q <= '0; item_q <= '0; found_q <= 1'b0; sel_q <= '0;
      lvl_q <= '0; run_q <= '0; sel_rec_q <= '0; prom_q <= '0;
      res_q <= '0; res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      q0_q <= q0_d; q1_q <= q1_d; q2_q <= q2_d; age_q <= age_d;
      elapsed_q <= elapsed_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d; item_q <= item_d; found_q <= found_d; sel_q <= sel_d;
      lvl_q <= lvl_d; run_q <= run_d; sel_rec_q <= sel_rec_d; prom_q <= prom_d;
      res_q <= res_d; res_v_q <= res_v_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = res_v_q;
  assign out_data_o = res_q;

  `MLFQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")
  `MLFQ_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_data_o), "result changed")
  `MLFQ_ASSERT(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE |-> !in_ready_o, "accept while busy")
  `MLFQ_ASSERT(a_cfg_idle, clk_i, rst_ni, cfg_ready_o |-> state_q == S_IDLE, "config while busy")
endmodule
`default_nettype wire
